### design/stpm_pkg.sv
package stpm_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int TAPS        = 12;
    localparam int PHASES      = 4;
    localparam int COEF_W      = 24;
    localparam int COEF_FRAC   = 22;

    localparam int TAP_W  = $clog2(TAPS);
    localparam int PH_W   = $clog2(PHASES);
    localparam int PROD_W = SAMPLE_BITS + COEF_W;
    localparam int ACC_W  = PROD_W + TAP_W;
    localparam int RND_W  = ACC_W - COEF_FRAC;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic        [SAMPLE_BITS-1:0] peak_t;
    typedef logic signed [COEF_W-1:0]      coef_t;

    // Kaiser-windowed sinc, four phases of twelve taps, signed Q.22.
    // Every phase sums to exactly 2^22.
    localparam int COEF_TABLE [PHASES][TAPS] = '{
        '{  -55,   2231, -14804,  57304, -171351,  528832,
          4079094, -385326, 131909, -42203,   9862,  -1189},
        '{ -533,   9338, -51979, 184834, -536886, 1876437,
          3230051, -701016, 243779, -73621,  15263,  -1363},
        '{-1363,  15263, -73621, 243779, -701016, 3230051,
          1876437, -536886, 184834, -51979,   9338,   -533},
        '{-1189,   9862, -42203, 131909, -385326, 4079094,
           528832, -171351,  57304, -14804,   2231,    -55}
    };

    // Magnitude of a sample; the most negative sample maps to 2^(SAMPLE_BITS-1).
    function automatic peak_t abs_sample(sample_t s);
        peak_t raw;
        raw = peak_t'(s);
        if (s[SAMPLE_BITS-1]) begin
            return (~raw) + peak_t'(1);
        end
        return raw;
    endfunction

    function automatic peak_t peak_max(peak_t a, peak_t b);
        return (a > b) ? a : b;
    endfunction

endpackage

### design/stereo_true_peak_meter.sv
// Stereo true-peak meter with 4x polyphase oversampling.
//
// Input channel (s_*): one audio frame per transfer. s_tdata carries the left
// and right samples, s_tuser the mono mode and clear flags, s_tlast marks the
// last frame of a host block. Output channel (m_*): one transfer per frame
// carrying the four running peaks after that frame.
//
// A frame is handled by one shared 24x24 multiplier that walks the four
// coefficient phases and twelve taps of each channel, one product per cycle,
// feeding a three-stage product/accumulate/round pipeline. A mono frame
// walks the left channel only. The next frame is taken only after the
// pipeline has drained and the result has been loaded into the output
// register; s_tready is low while a frame is being measured.
//
// The finished result sits in an output register; a stalled receiver does
// not stop the next frame from being accepted, but a frame that finishes
// while the previous result is still untaken waits until it is taken.
// Reset clears both histories, all four peaks and the output valid flag, not its data.
module stereo_true_peak_meter (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [23:0] left_sample, [47:24] right_sample
    input  logic [2*stpm_pkg::SAMPLE_BITS-1:0]  s_tdata,
    // [0] mode, [1] clear_peaks
    input  logic [1:0]                          s_tuser,
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [23:0] sample_peak_left, [47:24] sample_peak_right,
    // [71:48] true_peak_left, [95:72] true_peak_right
    output logic [4*stpm_pkg::SAMPLE_BITS-1:0]  m_tdata
);

    localparam int SB     = stpm_pkg::SAMPLE_BITS;
    localparam int TAPS   = stpm_pkg::TAPS;
    localparam int PHASES = stpm_pkg::PHASES;
    localparam int TAP_W  = stpm_pkg::TAP_W;
    localparam int PH_W   = stpm_pkg::PH_W;
    localparam int PROD_W = stpm_pkg::PROD_W;
    localparam int ACC_W  = stpm_pkg::ACC_W;
    localparam int RND_W  = stpm_pkg::RND_W;
    localparam int FRAC   = stpm_pkg::COEF_FRAC;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MAC   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]        state_reg;
    logic              ch_reg;
    logic [PH_W-1:0]   ph_reg;
    logic [TAP_W-1:0]  tap_reg;
    logic              mono_reg;
    logic              last_reg;

    stpm_pkg::sample_t hist_l_reg [TAPS];
    stpm_pkg::sample_t hist_r_reg [TAPS];
    stpm_pkg::peak_t   spk_l_reg, spk_r_reg, tpk_l_reg, tpk_r_reg;

    logic signed [PROD_W-1:0] prod_reg;
    logic                     v1_reg, first1_reg, end1_reg, ch1_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     v2_reg, ch2_reg;
    stpm_pkg::peak_t          rnd_reg;
    logic                     v3_reg, ch3_reg;

    logic              out_valid_reg;
    logic [4*SB-1:0]   out_data_reg;

    // Input frame fields.
    stpm_pkg::sample_t in_left, in_right;
    logic              in_mono, in_clear, accept;
    stpm_pkg::peak_t   mag_l, mag_r;
    stpm_pkg::peak_t   base_spk_l, base_spk_r, base_tpk_l, base_tpk_r;

    assign in_left  = s_tdata[SB-1:0];
    assign in_right = s_tdata[2*SB-1:SB];
    assign in_mono  = s_tuser[0];
    assign in_clear = s_tuser[1];
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign mag_l      = stpm_pkg::abs_sample(in_left);
    assign mag_r      = stpm_pkg::abs_sample(in_right);
    assign base_spk_l = in_clear ? '0 : spk_l_reg;
    assign base_spk_r = in_clear ? '0 : spk_r_reg;
    assign base_tpk_l = in_clear ? '0 : tpk_l_reg;
    assign base_tpk_r = in_clear ? '0 : tpk_r_reg;

    // Shared multiplier operands.
    stpm_pkg::coef_t          coef_sel;
    stpm_pkg::sample_t        hist_sel;
    logic signed [PROD_W-1:0] prod_next;
    logic                     tap_end, ph_end;

    assign coef_sel  = stpm_pkg::coef_t'(stpm_pkg::COEF_TABLE[ph_reg][tap_reg]);
    assign hist_sel  = ch_reg ? hist_r_reg[tap_reg] : hist_l_reg[tap_reg];
    assign prod_next = PROD_W'(coef_sel) * PROD_W'(hist_sel);
    assign tap_end   = (tap_reg == TAP_W'(TAPS - 1));
    assign ph_end    = (ph_reg == PH_W'(PHASES - 1));

    // Round the magnitude of the accumulator half away from zero in one add:
    // for a negative sum, -acc + half equals ~acc + half + 1.
    logic             acc_neg;
    logic [ACC_W-1:0] acc_opnd, acc_rnd_add, acc_sum;
    logic [RND_W-1:0] rnd_q;
    stpm_pkg::peak_t  rnd_next;

    assign acc_neg     = acc_reg[ACC_W-1];
    assign acc_opnd    = acc_neg ? ~acc_reg : acc_reg;
    assign acc_rnd_add = acc_neg ? (ACC_W'(1) << (FRAC - 1)) + ACC_W'(1)
                                 : (ACC_W'(1) << (FRAC - 1));
    assign acc_sum     = acc_opnd + acc_rnd_add;
    assign rnd_q       = acc_sum[ACC_W-1:FRAC];
    assign rnd_next    = (|rnd_q[RND_W-1:SB]) ? '1 : rnd_q[SB-1:0];

    // End-of-block mirroring for mono frames.
    logic            mirror;
    stpm_pkg::peak_t fin_spk_r, fin_tpk_r;
    logic            out_load;

    assign mirror    = mono_reg && last_reg;
    assign fin_spk_r = mirror ? stpm_pkg::peak_max(spk_r_reg, spk_l_reg) : spk_r_reg;
    assign fin_tpk_r = mirror ? stpm_pkg::peak_max(tpk_r_reg, tpk_l_reg) : tpk_r_reg;
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            ch_reg        <= 1'b0;
            ph_reg        <= '0;
            tap_reg       <= '0;
            mono_reg      <= 1'b0;
            last_reg      <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            spk_l_reg     <= '0;
            spk_r_reg     <= '0;
            tpk_l_reg     <= '0;
            tpk_r_reg     <= '0;
            for (int i = 0; i < TAPS; i++) begin
                hist_l_reg[i] <= '0;
                hist_r_reg[i] <= '0;
            end
        end else begin
            // Pipeline stage 1: one product per cycle while sequencing.
            v1_reg     <= (state_reg == ST_MAC);
            first1_reg <= (tap_reg == '0);
            end1_reg   <= tap_end;
            ch1_reg    <= ch_reg;
            prod_reg   <= prod_next;

            // Stage 2: accumulate one phase.
            if (v1_reg) begin
                acc_reg <= first1_reg ? ACC_W'(prod_reg) : acc_reg + ACC_W'(prod_reg);
            end
            v2_reg  <= v1_reg && end1_reg;
            ch2_reg <= ch1_reg;

            // Stage 3: rounded, saturated magnitude.
            v3_reg  <= v2_reg;
            ch3_reg <= ch2_reg;
            rnd_reg <= rnd_next;

            // Stage 4: fold into the true peak of its channel.
            if (v3_reg) begin
                if (ch3_reg) begin
                    tpk_r_reg <= stpm_pkg::peak_max(tpk_r_reg, rnd_reg);
                end else begin
                    tpk_l_reg <= stpm_pkg::peak_max(tpk_l_reg, rnd_reg);
                end
            end

            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        mono_reg  <= in_mono;
                        last_reg  <= s_tlast;
                        ch_reg    <= 1'b0;
                        ph_reg    <= '0;
                        tap_reg   <= '0;
                        state_reg <= ST_MAC;
                        // Clear first, then push the new samples and update
                        // the sample peaks and the plain-sample true peaks.
                        for (int i = 1; i < TAPS; i++) begin
                            hist_l_reg[i] <= in_clear ? '0 : hist_l_reg[i-1];
                        end
                        hist_l_reg[0] <= in_left;
                        spk_l_reg     <= stpm_pkg::peak_max(base_spk_l, mag_l);
                        tpk_l_reg     <= stpm_pkg::peak_max(base_tpk_l, mag_l);
                        if (!in_mono) begin
                            for (int i = 1; i < TAPS; i++) begin
                                hist_r_reg[i] <= in_clear ? '0 : hist_r_reg[i-1];
                            end
                            hist_r_reg[0] <= in_right;
                            spk_r_reg     <= stpm_pkg::peak_max(base_spk_r, mag_r);
                            tpk_r_reg     <= stpm_pkg::peak_max(base_tpk_r, mag_r);
                        end else if (in_clear) begin
                            for (int i = 0; i < TAPS; i++) begin
                                hist_r_reg[i] <= '0;
                            end
                            spk_r_reg <= '0;
                            tpk_r_reg <= '0;
                        end
                    end
                end
                ST_MAC: begin
                    if (tap_end) begin
                        tap_reg <= '0;
                        if (ph_end) begin
                            ph_reg <= '0;
                            if (ch_reg || mono_reg) begin
                                state_reg <= ST_DRAIN;
                            end else begin
                                ch_reg <= 1'b1;
                            end
                        end else begin
                            ph_reg <= ph_reg + PH_W'(1);
                        end
                    end else begin
                        tap_reg <= tap_reg + TAP_W'(1);
                    end
                end
                ST_DRAIN: begin
                    if (!v1_reg && !v2_reg && !v3_reg) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_load) begin
                        spk_r_reg    <= fin_spk_r;
                        tpk_r_reg    <= fin_tpk_r;
                        out_data_reg <= {fin_tpk_r, tpk_l_reg, fin_spk_r, spk_l_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

### design/stpm_checker.sv
module stpm_port_checks (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [4*stpm_pkg::SAMPLE_BITS-1:0]  m_tdata
);

    localparam int SB = stpm_pkg::SAMPLE_BITS;

    stpm_pkg::peak_t spk_l, spk_r, tpk_l, tpk_r;

    assign spk_l = m_tdata[SB-1:0];
    assign spk_r = m_tdata[2*SB-1:SB];
    assign tpk_l = m_tdata[3*SB-1:2*SB];
    assign tpk_r = m_tdata[4*SB-1:3*SB];

    // A stalled result holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // After a frame transfer the block is busy measuring it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a frame is in work");

    // A true peak never falls below the sample peak of its channel.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (spk_l <= tpk_l) && (spk_r <= tpk_r))
        else $error("sample peak above true peak");

    // Reset leaves the block empty and ready.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("block not idle after reset");

endmodule

bind stereo_true_peak_meter stpm_port_checks u_stpm_port_checks (.*);

### bench/stpm_checker.sv
`timescale 1ns / 1ps

module stpm_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    // [23:0] left_sample, [47:24] right_sample
    input  logic [2*stpm_pkg::SAMPLE_BITS-1:0] s_tdata,
    // [0] mode, [1] clear_peaks
    input  logic [1:0]                         s_tuser,
    input  logic                               s_tlast,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    // [23:0] sample_peak_left, [47:24] sample_peak_right,
    // [71:48] true_peak_left, [95:72] true_peak_right
    input  logic [4*stpm_pkg::SAMPLE_BITS-1:0] m_tdata,
    output int                                 fail_count,
    output int                                 pending
);

    localparam int SB        = stpm_pkg::SAMPLE_BITS;
    localparam int NTAPS     = 12;
    localparam int NPHASES   = 4;
    localparam int FRAC_BITS = 22;
    localparam int CH_LEFT   = 0;
    localparam int CH_RIGHT  = 1;
    localparam int USER_MONO  = 0;
    localparam int USER_CLEAR = 1;
    localparam int PRINT_LIMIT = 30;
    localparam logic [SB-1:0] PEAK_CEIL = '1;

    // Interpolation filter, signed Q.22, one row per output phase.
    localparam int FILTER_COEFS [NPHASES][NTAPS] = '{
        '{  -55,    2231, -14804,  57304, -171351,  528832,
          4079094, -385326, 131909, -42203,    9862,   -1189},
        '{ -533,    9338, -51979, 184834, -536886, 1876437,
          3230051, -701016, 243779, -73621,   15263,   -1363},
        '{-1363,   15263, -73621, 243779, -701016, 3230051,
          1876437, -536886, 184834, -51979,    9338,    -533},
        '{-1189,    9862, -42203, 131909, -385326, 4079094,
           528832, -171351,  57304, -14804,    2231,     -55}
    };

    // Field order matches m_tdata, so a cast lines the fields up.
    typedef struct packed {
        stpm_pkg::peak_t true_right;
        stpm_pkg::peak_t true_left;
        stpm_pkg::peak_t samp_right;
        stpm_pkg::peak_t samp_left;
    } meter_reading_t;

    stpm_pkg::sample_t history  [2][NTAPS];
    stpm_pkg::peak_t   samp_peak[2];
    stpm_pkg::peak_t   true_peak[2];
    meter_reading_t    readings_due[$];

    function automatic stpm_pkg::peak_t sample_mag(stpm_pkg::sample_t s);
        longint v;
        v = longint'(s);
        return stpm_pkg::peak_t'(v < 0 ? -v : v);
    endfunction

    task automatic report_mismatch(input string msg);
        if (fail_count < PRINT_LIMIT)
            $display("%0t ns: %s", $time, msg);
        fail_count++;
    endtask

    task automatic clear_meter();
        for (int ch = 0; ch < 2; ch++) begin
            for (int m = 0; m < NTAPS; m++)
                history[ch][m] = '0;
            samp_peak[ch] = '0;
            true_peak[ch] = '0;
        end
    endtask

    // Push one sample into a channel and fold it and all interpolated
    // points into that channel's peaks.
    task automatic measure(input int ch, input stpm_pkg::sample_t s);
        stpm_pkg::peak_t a;
        longint acc;
        longint mag;
        a = sample_mag(s);
        if (a > samp_peak[ch]) samp_peak[ch] = a;
        if (a > true_peak[ch]) true_peak[ch] = a;
        for (int m = NTAPS - 1; m > 0; m--)
            history[ch][m] = history[ch][m-1];
        history[ch][0] = s;
        for (int p = 0; p < NPHASES; p++) begin
            acc = 0;
            for (int m = 0; m < NTAPS; m++)
                acc += longint'(FILTER_COEFS[p][m]) * longint'(history[ch][m]);
            mag = acc < 0 ? -acc : acc;
            // Rounds the magnitude half away from zero.
            mag = (mag + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
            if (mag > longint'(PEAK_CEIL)) mag = longint'(PEAK_CEIL);
            if (mag > longint'(true_peak[ch])) true_peak[ch] = stpm_pkg::peak_t'(mag);
        end
    endtask

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    always @(posedge aclk) begin
        meter_reading_t got;
        meter_reading_t want;
        logic mono;
        if (!aresetn) begin
            clear_meter();
            readings_due.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = meter_reading_t'(m_tdata);
                if (readings_due.size() == 0) begin
                    report_mismatch($sformatf("result transfer %h with none pending", m_tdata));
                end else begin
                    want = readings_due.pop_front();
                    if (got.samp_left != want.samp_left)
                        report_mismatch($sformatf("sample_peak_left %h, expected %h",
                                                  got.samp_left, want.samp_left));
                    if (got.samp_right != want.samp_right)
                        report_mismatch($sformatf("sample_peak_right %h, expected %h",
                                                  got.samp_right, want.samp_right));
                    if (got.true_left != want.true_left)
                        report_mismatch($sformatf("true_peak_left %h, expected %h",
                                                  got.true_left, want.true_left));
                    if (got.true_right != want.true_right)
                        report_mismatch($sformatf("true_peak_right %h, expected %h",
                                                  got.true_right, want.true_right));
                end
            end
            if (s_tvalid && s_tready) begin
                mono = s_tuser[USER_MONO];
                if (s_tuser[USER_CLEAR]) clear_meter();
                measure(CH_LEFT, stpm_pkg::sample_t'(s_tdata[SB-1:0]));
                if (!mono)
                    measure(CH_RIGHT, stpm_pkg::sample_t'(s_tdata[2*SB-1:SB]));
                if (mono && s_tlast) begin
                    if (samp_peak[CH_LEFT] > samp_peak[CH_RIGHT])
                        samp_peak[CH_RIGHT] = samp_peak[CH_LEFT];
                    if (true_peak[CH_LEFT] > true_peak[CH_RIGHT])
                        true_peak[CH_RIGHT] = true_peak[CH_LEFT];
                end
                want.samp_left  = samp_peak[CH_LEFT];
                want.samp_right = samp_peak[CH_RIGHT];
                want.true_left  = true_peak[CH_LEFT];
                want.true_right = true_peak[CH_RIGHT];
                readings_due.push_back(want);
            end
        end
        pending <= readings_due.size();
    end

endmodule

### bench/tb_stereo_true_peak_meter.sv
`timescale 1ns / 1ps

module tb_stereo_true_peak_meter;

    localparam int SB            = stpm_pkg::SAMPLE_BITS;
    localparam int RANDOM_FRAMES = 850;
    localparam int MAX_GAP       = 18;
    localparam int HOLD_CYCLES   = 2500;
    localparam int DRAIN_CYCLES  = 120;
    localparam int CYCLE_LIMIT   = 600000;
    localparam logic MODE_STEREO = 1'b0;
    localparam logic MODE_MONO   = 1'b1;
    // Bit m is set where tap m of every filter phase is positive.
    localparam logic [11:0] COEF_SIGNS = 12'h56A;
    localparam logic [SB-1:0] FULL_POS = 24'h7FFFFF;
    localparam logic [SB-1:0] FULL_NEG = 24'h800000;

    logic          aclk;
    logic          aresetn;
    logic          s_tvalid;
    logic          s_tready;
    logic [2*SB-1:0] s_tdata;
    logic [1:0]    s_tuser;
    logic          s_tlast;
    logic          m_tvalid;
    logic          m_tready;
    logic [4*SB-1:0] m_tdata;

    int fail_count;
    int pending;
    int cycle_count;
    int sent_count;
    bit tx_quiet;

    stereo_true_peak_meter dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    stpm_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial cycle_count = 0;
    always @(posedge aclk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb_stereo_true_peak_meter failed");
        $finish;
    end

    function automatic int draw_gap(bit quiet);
        return quiet ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    function automatic logic [SB-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return SB'($urandom);
            4: begin
                case ($urandom_range(0, 4))
                    0: return FULL_POS;
                    1: return FULL_NEG;
                    2: return '0;
                    3: return 24'h000001;
                    default: return 24'hFFFFFF;
                endcase
            end
            5, 6: return SB'(int'($urandom_range(0, 1023)) - 512);
            default: return {$urandom_range(0, 1) == 1, 1'b1, 22'($urandom)};
        endcase
    endfunction

    task automatic send_frame(input logic [SB-1:0] left, input logic [SB-1:0] right,
                              input logic mode, input logic clr, input logic last);
        int gap;
        if (sent_count % 64 == 0) tx_quiet = ($urandom_range(0, 3) == 0);
        gap = draw_gap(tx_quiet);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {right, left};
        s_tuser  <= {clr, mode};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_count++;
    endtask

    // Twelve frames whose signs follow the filter taps, so the interpolated
    // points overshoot well beyond the samples themselves.
    task automatic send_pattern_run(input logic [SB-1:0] amp, input logic mode,
                                    input logic clr_first);
        logic [SB-1:0] lv;
        for (int j = 0; j < 12; j++) begin
            lv = COEF_SIGNS[11-j] ? amp : -amp;
            send_frame(lv, -lv, mode, clr_first && j == 0, 1'b0);
        end
    endtask

    // The sender goes quiet first so the last frame is not offered again.
    // The pending count is a registered copy of the checker's queue size.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    initial begin : result_sink
        int gap;
        int taken;
        bit quiet;
        taken = 0;
        quiet = 1'b0;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (taken % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
            // Two long stalls let the meter fill up and hold off its input.
            gap = (taken == 40 || taken == 450) ? HOLD_CYCLES : draw_gap(quiet);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            taken++;
        end
    end

    initial begin : frame_source
        int i;
        logic rnd_mode;
        logic [SB-1:0] l_smp;
        aresetn    <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tuser    <= '0;
        s_tlast    <= 1'b0;
        sent_count = 0;
        tx_quiet   = 1'b0;
        rnd_mode   = MODE_STEREO;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_frame('0, '0, MODE_STEREO, 1'b0, 1'b0);
        send_frame(FULL_NEG, FULL_POS, MODE_STEREO, 1'b0, 1'b0);
        // Mono end of block with the left peak above the right one.
        send_frame(FULL_NEG, FULL_POS, MODE_MONO, 1'b0, 1'b1);
        // Stereo end of block leaves the right channel alone.
        send_frame(24'h000001, 24'hFFFFFF, MODE_STEREO, 1'b0, 1'b1);
        send_frame(24'h000001, 24'hFFFFFF, MODE_STEREO, 1'b1, 1'b0);
        send_frame(24'h400000, 24'h123456, MODE_MONO, 1'b0, 1'b0);
        send_frame(24'hC00000, '0, MODE_MONO, 1'b0, 1'b1);
        send_pattern_run(FULL_POS, MODE_STEREO, 1'b1);
        send_frame('0, '0, MODE_MONO, 1'b1, 1'b1);
        send_frame(FULL_POS, FULL_NEG, MODE_STEREO, 1'b1, 1'b1);
        send_frame(FULL_NEG, FULL_POS, MODE_MONO, 1'b1, 1'b1);
        wait_drained();

        i = 0;
        while (i < RANDOM_FRAMES) begin
            if (i >= 300 && i < 312) wait_drained();
            if ($urandom_range(0, 19) == 0)
                rnd_mode = (rnd_mode == MODE_MONO) ? MODE_STEREO : MODE_MONO;
            if ($urandom_range(0, 14) == 0) begin
                send_pattern_run(SB'($urandom_range(24'h600000, 24'h7FFFFF)), rnd_mode,
                                 $urandom_range(0, 3) == 0);
                i += 12;
            end else begin
                l_smp = pick_sample();
                send_frame(l_smp, pick_sample(), rnd_mode,
                           $urandom_range(0, 39) == 0, $urandom_range(0, 7) == 0);
                i++;
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("tb_stereo_true_peak_meter passed");
        else
            $display("tb_stereo_true_peak_meter failed");
        $finish;
    end

endmodule
